FILE: rtl/rlcsp_pkg.sv
package rlcsp_pkg;

  // sizing
  localparam int MAX_BLOCK_BYTES = 64;
  localparam int MAX_LIS         = 32;

  // fixed field widths
  localparam int LEN_W      = 7;
  localparam int CHUNK_W    = 11;
  localparam int OCTET_W    = 8;
  localparam int LI_LEN_W   = 6;
  localparam int LI_CNT_W   = $clog2(MAX_LIS + 1);
  localparam int LI_IDX_W   = $clog2(MAX_LIS);

  localparam logic [LEN_W-1:0]    MAX_DLEN    = LEN_W'(MAX_BLOCK_BYTES);
  localparam logic [LEN_W-1:0]    CFG_RESET   = 7'd20;
  localparam logic [LI_CNT_W-1:0] LI_CNT_FULL = LI_CNT_W'(MAX_LIS);

  // length indicator octet bits
  localparam logic [OCTET_W-1:0] LI_M_BIT  = 8'h02;
  localparam logic [OCTET_W-1:0] LI_E_MASK = 8'hfe;
  localparam logic [OCTET_W-1:0] LI_E_BIT  = 8'h01;

  typedef enum logic {
    OP_APPEND  = 1'b0,
    OP_READOUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_NEED_MORE  = 2'd0,
    ST_FILLED     = 2'd1,
    ST_SPACE_LEFT = 2'd2,
    ST_READOUT    = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch chunk fields of an accepted item
    logic append;    // commit append and load result
    logic rd_first;  // restart readout index
    logic rd_load;   // load one readout octet, advance index
    logic clear;     // empty the block
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic li_none;   // no LI octets stored
    logic rd_last;   // readout index is at the last stored octet
  } sts_t;

endpackage

FILE: rtl/rlcsp_if.sv
interface rlcsp_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [rlcsp_pkg::CHUNK_W-1:0]     chunk_len;
  logic                              final_block;

  modport source (output valid, output operation, output chunk_len, output final_block,
                  input ready);
  modport sink   (input valid, input operation, input chunk_len, input final_block,
                  output ready);
endinterface

interface rlcsp_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [rlcsp_pkg::LEN_W-1:0]       taken_count;
  logic [rlcsp_pkg::LEN_W-1:0]       fill_offset;
  logic                              ext_present;
  logic [rlcsp_pkg::OCTET_W-1:0]     li_octet;
  logic                              last_octet;

  modport source (output valid, output status, output taken_count, output fill_offset,
                  output ext_present, output li_octet, output last_octet, input ready);
  modport sink   (input valid, input status, input taken_count, input fill_offset,
                  input ext_present, input li_octet, input last_octet, output ready);
endinterface

FILE: rtl/rlcsp_ctrl.sv
module rlcsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rlcsp_pkg::sts_t   sts,
  output rlcsp_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPEND,
    S_RD_ADDR,
    S_RD_DATA
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (in_operation == rlcsp_pkg::OP_APPEND) begin
            state_nxt = S_APPEND;
          end else if (sts.li_none) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.rd_first = 1'b1;
            state_nxt    = S_RD_ADDR;
          end
        end
      end
      S_APPEND: begin
        if (out_free) begin
          cmd.append = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (out_free) begin
          cmd.rd_load = 1'b1;
          if (sts.rd_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD_ADDR;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.append || cmd.rd_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/rlcsp_dpath.sv
module rlcsp_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rlcsp_pkg::LEN_W-1:0]     cfg_wdata,
  input  logic [rlcsp_pkg::CHUNK_W-1:0]   in_chunk_len,
  input  logic                            in_final_block,
  input  rlcsp_pkg::cmd_t                 cmd,
  output rlcsp_pkg::sts_t                 sts,
  output logic [1:0]                      out_status,
  output logic [rlcsp_pkg::LEN_W-1:0]     out_taken_count,
  output logic [rlcsp_pkg::LEN_W-1:0]     out_fill_offset,
  output logic                            out_ext_present,
  output logic [rlcsp_pkg::OCTET_W-1:0]   out_li_octet,
  output logic                            out_last_octet
);

  // block state
  logic [rlcsp_pkg::LEN_W-1:0]    bdl_r, bdl_nxt;
  logic [rlcsp_pkg::LEN_W-1:0]    fill_pos_r, fill_pos_nxt;
  logic [rlcsp_pkg::LI_CNT_W-1:0] li_total_r, li_total_nxt;
  logic                           ext_r, ext_nxt;
  // newest LI octet lives here, older ones in the store
  logic [rlcsp_pkg::OCTET_W-1:0]  tail_r, tail_nxt;
  logic [rlcsp_pkg::OCTET_W-1:0]  li_mem [rlcsp_pkg::MAX_LIS];
  logic [rlcsp_pkg::OCTET_W-1:0]  rdata_r;
  logic [rlcsp_pkg::LI_IDX_W-1:0] idx_r, idx_nxt;
  logic [rlcsp_pkg::CHUNK_W-1:0]  chunk_r;
  logic                           final_r;

  // result register
  rlcsp_pkg::status_t             o_status_r, o_status_nxt;
  logic [rlcsp_pkg::LEN_W-1:0]    o_taken_r, o_taken_nxt;
  logic [rlcsp_pkg::LEN_W-1:0]    o_fill_r, o_fill_nxt;
  logic                           o_ext_r, o_ext_nxt;
  logic [rlcsp_pkg::OCTET_W-1:0]  o_li_r, o_li_nxt;
  logic                           o_last_r, o_last_nxt;

  // append evaluation
  logic [rlcsp_pkg::LEN_W-1:0]    dlen;
  logic [rlcsp_pkg::LEN_W-1:0]    space;
  logic [rlcsp_pkg::CHUNK_W-1:0]  space_x;
  logic [rlcsp_pkg::LEN_W-1:0]    chunk_s;
  logic                           blk_full, over, fit, has_prev, lis_full;
  logic                           add_li;
  rlcsp_pkg::status_t             a_status;
  logic [rlcsp_pkg::LEN_W-1:0]    a_taken, a_fill;
  logic [rlcsp_pkg::OCTET_W-1:0]  a_tail, new_li;
  logic [rlcsp_pkg::LI_IDX_W-1:0] wr_idx;
  logic [rlcsp_pkg::OCTET_W-1:0]  rd_octet;

  assign dlen     = (int'(bdl_r) > rlcsp_pkg::MAX_BLOCK_BYTES) ? rlcsp_pkg::MAX_DLEN : bdl_r;
  assign blk_full = (fill_pos_r >= dlen);
  assign space    = dlen - fill_pos_r;
  assign space_x  = rlcsp_pkg::CHUNK_W'(space);
  assign chunk_s  = chunk_r[rlcsp_pkg::LEN_W-1:0];
  assign over     = (chunk_r > space_x);
  assign fit      = (chunk_r == space_x);
  assign has_prev = (li_total_r != '0);
  assign lis_full = (li_total_r == rlcsp_pkg::LI_CNT_FULL);
  assign wr_idx   = rlcsp_pkg::LI_IDX_W'(li_total_r - rlcsp_pkg::LI_CNT_W'(1));

  assign sts.li_none = !has_prev;
  assign sts.rd_last = ((rlcsp_pkg::LI_CNT_W'(idx_r) + rlcsp_pkg::LI_CNT_W'(1)) == li_total_r);
  assign rd_octet    = sts.rd_last ? tail_r : rdata_r;

  always_comb begin
    a_status = rlcsp_pkg::ST_FILLED;
    a_taken  = '0;
    a_fill   = fill_pos_r;
    a_tail   = tail_r;
    add_li   = 1'b0;
    new_li   = rlcsp_pkg::LI_E_BIT;
    if (!blk_full) begin
      if (over) begin
        // frame runs on into the next block
        if (has_prev) begin
          a_tail = tail_r | rlcsp_pkg::LI_M_BIT;
        end
        a_taken  = space;
        a_fill   = dlen;
        a_status = rlcsp_pkg::ST_NEED_MORE;
      end else if (fit && final_r) begin
        if (has_prev) begin
          a_tail = tail_r | rlcsp_pkg::LI_E_BIT;
        end
        a_taken  = space;
        a_fill   = dlen;
        a_status = rlcsp_pkg::ST_FILLED;
      end else if (!lis_full) begin
        add_li = 1'b1;
        if (fit) begin
          // LI of zero marks the frame as ending exactly one octet short
          new_li   = rlcsp_pkg::LI_E_BIT;
          a_taken  = space - rlcsp_pkg::LEN_W'(1);
          a_fill   = dlen;
          a_status = rlcsp_pkg::ST_NEED_MORE;
        end else begin
          new_li   = {chunk_r[rlcsp_pkg::LI_LEN_W-1:0], 2'b00} | rlcsp_pkg::LI_E_BIT;
          a_taken  = chunk_s;
          a_fill   = fill_pos_r + rlcsp_pkg::LEN_W'(1) + chunk_s;
          a_status = ((chunk_s + rlcsp_pkg::LEN_W'(1)) < space && !final_r) ?
                     rlcsp_pkg::ST_SPACE_LEFT : rlcsp_pkg::ST_FILLED;
        end
        a_tail = new_li;
      end
    end
  end

  always_comb begin
    bdl_nxt      = cfg_we ? cfg_wdata : bdl_r;
    fill_pos_nxt = fill_pos_r;
    li_total_nxt = li_total_r;
    ext_nxt      = ext_r;
    tail_nxt     = tail_r;
    idx_nxt      = idx_r;
    o_status_nxt = o_status_r;
    o_taken_nxt  = o_taken_r;
    o_fill_nxt   = o_fill_r;
    o_ext_nxt    = o_ext_r;
    o_li_nxt     = o_li_r;
    o_last_nxt   = o_last_r;
    if (cmd.append) begin
      fill_pos_nxt = a_fill;
      tail_nxt     = a_tail;
      if (add_li) begin
        li_total_nxt = li_total_r + rlcsp_pkg::LI_CNT_W'(1);
        ext_nxt      = 1'b1;
      end
      o_status_nxt = a_status;
      o_taken_nxt  = a_taken;
      o_fill_nxt   = a_fill;
      o_ext_nxt    = add_li ? 1'b1 : ext_r;
      o_li_nxt     = '0;
      o_last_nxt   = 1'b0;
    end
    if (cmd.rd_first) begin
      idx_nxt = '0;
    end
    if (cmd.rd_load) begin
      idx_nxt      = idx_r + rlcsp_pkg::LI_IDX_W'(1);
      o_status_nxt = rlcsp_pkg::ST_READOUT;
      o_taken_nxt  = '0;
      o_fill_nxt   = fill_pos_r;
      o_ext_nxt    = ext_r;
      o_li_nxt     = rd_octet;
      o_last_nxt   = sts.rd_last;
    end
    if (cmd.clear) begin
      fill_pos_nxt = '0;
      li_total_nxt = '0;
      ext_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bdl_r      <= rlcsp_pkg::CFG_RESET;
      fill_pos_r <= '0;
      li_total_r <= '0;
      ext_r      <= 1'b0;
      idx_r      <= '0;
    end else begin
      bdl_r      <= bdl_nxt;
      fill_pos_r <= fill_pos_nxt;
      li_total_r <= li_total_nxt;
      ext_r      <= ext_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      chunk_r <= in_chunk_len;
      final_r <= in_final_block;
    end
    tail_r     <= tail_nxt;
    o_status_r <= o_status_nxt;
    o_taken_r  <= o_taken_nxt;
    o_fill_r   <= o_fill_nxt;
    o_ext_r    <= o_ext_nxt;
    o_li_r     <= o_li_nxt;
    o_last_r   <= o_last_nxt;
  end

  // LI store: superseded tail octet is written back already linked (E clear, M set)
  always_ff @(posedge clk) begin
    if (cmd.append && add_li && has_prev) begin
      li_mem[wr_idx] <= (tail_r & rlcsp_pkg::LI_E_MASK) | rlcsp_pkg::LI_M_BIT;
    end
    rdata_r <= li_mem[idx_r];
  end

  assign out_status      = o_status_r;
  assign out_taken_count = o_taken_r;
  assign out_fill_offset = o_fill_r;
  assign out_ext_present = o_ext_r;
  assign out_li_octet    = o_li_r;
  assign out_last_octet  = o_last_r;

endmodule

FILE: rtl/rlc_block_segment_packer.sv
// append: item captured, then evaluated and loaded into the result register once that is free; input closed meanwhile
// readout of n LI octets: an address step and a data step per octet, set by the registered read of the LI store
// readout with no LI octets stored: block emptied, no result
// result register frees the input side: a new item is taken while a result waits
// rst_n synchronous active low: block empty, block length register back to 20 octets
module rlc_block_segment_packer (
  input  logic                         clk,
  input  logic                         rst_n,
  rlcsp_in_if.sink                     in_chan,
  rlcsp_out_if.source                  out_chan,
  input  logic                         cfg_we,
  input  logic [rlcsp_pkg::LEN_W-1:0]  cfg_wdata
);

  // command and status between sequencer and datapath
  rlcsp_pkg::cmd_t cmd;
  rlcsp_pkg::sts_t sts;
  logic            in_ready;
  logic            out_valid;

  // sequencer: idle, append evaluation, readout address and data steps
  rlcsp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_chan.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // datapath: fill offset, LI count, tail LI register, LI store and result register
  rlcsp_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_chunk_len    (in_chan.chunk_len),
    .in_final_block  (in_chan.final_block),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (out_chan.status),
    .out_taken_count (out_chan.taken_count),
    .out_fill_offset (out_chan.fill_offset),
    .out_ext_present (out_chan.ext_present),
    .out_li_octet    (out_chan.li_octet),
    .out_last_octet  (out_chan.last_octet)
  );

  // handshake wiring
  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule

FILE: rtl/rlcsp_chk.sv
module rlcsp_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_operation,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic [rlcsp_pkg::LEN_W-1:0]   out_taken_count,
  input logic [rlcsp_pkg::LEN_W-1:0]   out_fill_offset,
  input logic                          out_last_octet
);

  // result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_taken_count) && $stable(out_fill_offset))
    else $error("result dropped or changed while stalled");

  // an append is evaluated before the next item: no transfer in the cycle after it
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == rlcsp_pkg::OP_APPEND |=> !in_ready)
    else $error("input taken while previous item still in work");

  // a readout run keeps the input closed until its last octet is loaded
  a_rd_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == 2'(rlcsp_pkg::ST_READOUT) && !out_last_octet
      |-> !in_ready)
    else $error("input opened in the middle of a readout run");

  // octets taken never exceed the fill offset they belong to
  a_taken_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_taken_count <= out_fill_offset)
    else $error("taken count beyond fill offset");

endmodule

bind rlc_block_segment_packer rlcsp_chk u_rlcsp_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_operation    (in_chan.operation),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_taken_count (out_chan.taken_count),
  .out_fill_offset (out_chan.fill_offset),
  .out_last_octet  (out_chan.last_octet)
);

FILE: tb/sv/rlc_block_segment_packer_tb.sv
module rlc_block_segment_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlcsp_pkg::*;

  // run bounds
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;   // long receiver hold-off, once
  localparam int HOLD_AFTER  = 40;    // results seen before the hold-off starts
  localparam int SETTLE      = 12;    // covers a readout that yields nothing
  localparam int TAIL        = 40;
  localparam int RAND_PHASES = 6;
  localparam int RAND_ITEMS  = 17;    // per phase
  localparam int BURST_LIS   = 33;    // one more LI than the store holds

  // one result transfer as seen on the output channel
  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] taken;
    logic [LEN_W-1:0] fill;
    logic             ext;
    logic [7:0]       li;
    logic             last;
  } packer_result_t;

  // directed stimulus rows; the length write reuses the chunk field
  typedef enum logic [1:0] {
    ROW_APPEND,
    ROW_READOUT,
    ROW_SET_LEN
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [CHUNK_W-1:0] chunk;
    logic               fin;
    logic               typed;   // expected result written out below
    status_t            st;
    logic [LEN_W-1:0]   taken;
    logic [LEN_W-1:0]   fill;
    logic               ext;
  } stim_row_t;

  localparam int N_DIR = 28;

  // block length starts at its reset value of 20 octets
  stim_row_t dir_rows [N_DIR] = '{
    // short chunk, then overflow sets M on the first LI, then append to a full block
    '{ROW_APPEND,  11'd5,    1'b0, 1'b1, ST_SPACE_LEFT, 7'd5,  7'd6,  1'b1},
    '{ROW_APPEND,  11'd2047, 1'b0, 1'b1, ST_NEED_MORE,  7'd14, 7'd20, 1'b1},
    '{ROW_APPEND,  11'd3,    1'b1, 1'b1, ST_FILLED,     7'd0,  7'd20, 1'b1},
    '{ROW_READOUT, 11'd0,    1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0},
    // exact fit on a final block, no LI at all
    '{ROW_APPEND,  11'd20,   1'b1, 1'b1, ST_FILLED,     7'd20, 7'd20, 1'b0},
    '{ROW_READOUT, 11'd0,    1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0},
    // exact fit, not final: LI of zero length
    '{ROW_APPEND,  11'd20,   1'b0, 1'b1, ST_NEED_MORE,  7'd19, 7'd20, 1'b1},
    '{ROW_READOUT, 11'd0,    1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0},
    // final short chunk, then exact fit links the previous LI
    '{ROW_APPEND,  11'd10,   1'b1, 1'b1, ST_FILLED,     7'd10, 7'd11, 1'b1},
    '{ROW_APPEND,  11'd9,    1'b0, 1'b1, ST_NEED_MORE,  7'd8,  7'd20, 1'b1},
    '{ROW_READOUT, 11'd0,    1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0},
    // exact fit on a final block sets E on the previous LI
    '{ROW_APPEND,  11'd18,   1'b0, 1'b1, ST_SPACE_LEFT, 7'd18, 7'd19, 1'b1},
    '{ROW_APPEND,  11'd1,    1'b1, 1'b1, ST_FILLED,     7'd1,  7'd20, 1'b1},
    '{ROW_READOUT, 11'd0,    1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0},
    // shrinking the block under its fill leaves it full
    '{ROW_APPEND,  11'd15,   1'b0, 1'b1, ST_SPACE_LEFT, 7'd15, 7'd16, 1'b1},
    '{ROW_SET_LEN, 11'd10,   1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0},
    '{ROW_APPEND,  11'd3,    1'b0, 1'b1, ST_FILLED,     7'd0,  7'd16, 1'b1},
    '{ROW_READOUT, 11'd0,    1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0},
    // largest block: widest LI and widest counts
    '{ROW_SET_LEN, 11'd64,   1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0},
    '{ROW_APPEND,  11'd63,   1'b0, 1'b1, ST_FILLED,     7'd63, 7'd64, 1'b1},
    '{ROW_READOUT, 11'd0,    1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0},
    '{ROW_APPEND,  11'd64,   1'b1, 1'b1, ST_FILLED,     7'd64, 7'd64, 1'b0},
    '{ROW_READOUT, 11'd0,    1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0},
    // smallest block
    '{ROW_SET_LEN, 11'd1,    1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0},
    '{ROW_APPEND,  11'd0,    1'b0, 1'b1, ST_FILLED,     7'd0,  7'd1,  1'b1},
    '{ROW_READOUT, 11'd0,    1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0},
    '{ROW_APPEND,  11'd1,    1'b0, 1'b1, ST_NEED_MORE,  7'd0,  7'd1,  1'b1},
    '{ROW_READOUT, 11'd0,    1'b0, 1'b0, ST_READOUT,    7'd0,  7'd0,  1'b0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  rlcsp_in_if  in_chan ();
  rlcsp_out_if out_chan ();

  rlc_block_segment_packer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the block state and its length register
  logic [LEN_W-1:0] p_blen;
  int               p_fill;
  int               p_li_cnt;
  logic [7:0]       p_li [MAX_LIS];
  logic             p_ext;

  packer_result_t packer_results_due [$];

  int err_cnt      = 0;
  int results_seen = 0;
  int cycle_cnt    = 0;
  int snd_quiet    = 0;
  int rcv_quiet    = 0;

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the run hangs anywhere
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= 40)
      $display("mismatch on %s: got %0d want %0d (result %0d, cycle %0d)",
               what, got, want, results_seen, cycle_cnt);
  endtask

  // mostly back to back, some short gaps, a few long ones, and quiet stretches
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(15) == 0) quiet = $urandom_range(20, 40);
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void push_due(input status_t st, input int taken, input int fill,
                                   input logic ext, input logic [7:0] li, input logic last);
    packer_result_t r;
    r.status = st;
    r.taken  = LEN_W'(taken);
    r.fill   = LEN_W'(fill);
    r.ext    = ext;
    r.li     = li;
    r.last   = last;
    packer_results_due.push_back(r);
  endfunction

  // works out the results of one accepted item and moves the predictor state on
  function automatic void predict_packing(input op_t op, input logic [CHUNK_W-1:0] chunk,
                                          input logic fin);
    int dlen;
    int space;
    int c;
    int i;
    c = int'(chunk);
    if (op == OP_READOUT) begin
      // one octet per stored LI, then the block is emptied
      for (i = 0; i < p_li_cnt; i++)
        push_due(ST_READOUT, 0, p_fill, p_ext, p_li[i], i == p_li_cnt - 1);
      p_fill   = 0;
      p_li_cnt = 0;
      p_ext    = 1'b0;
      return;
    end
    dlen = (int'(p_blen) > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : int'(p_blen);
    if (p_fill >= dlen) begin
      push_due(ST_FILLED, 0, p_fill, p_ext, 8'h00, 1'b0);
      return;
    end
    space = dlen - p_fill;
    if (c > space) begin
      // frame carries on into the next block
      if (p_li_cnt > 0) p_li[p_li_cnt-1] = p_li[p_li_cnt-1] | LI_M_BIT;
      p_fill = dlen;
      push_due(ST_NEED_MORE, space, p_fill, p_ext, 8'h00, 1'b0);
    end else if (c == space && fin) begin
      if (p_li_cnt > 0) p_li[p_li_cnt-1] = p_li[p_li_cnt-1] | LI_E_BIT;
      p_fill = dlen;
      push_due(ST_FILLED, space, p_fill, p_ext, 8'h00, 1'b0);
    end else if (p_li_cnt >= MAX_LIS) begin
      // no room for another LI
      push_due(ST_FILLED, 0, p_fill, p_ext, 8'h00, 1'b0);
    end else begin
      if (p_li_cnt > 0) p_li[p_li_cnt-1] = (p_li[p_li_cnt-1] & LI_E_MASK) | LI_M_BIT;
      p_ext = 1'b1;
      if (c == space) begin
        p_li[p_li_cnt] = LI_E_BIT;
        p_li_cnt++;
        p_fill = dlen;
        push_due(ST_NEED_MORE, space - 1, p_fill, p_ext, 8'h00, 1'b0);
      end else begin
        p_li[p_li_cnt] = {chunk[LI_LEN_W-1:0], 2'b00} | LI_E_BIT;
        p_li_cnt++;
        p_fill = p_fill + 1 + c;
        push_due((space - 1 - c > 0 && !fin) ? ST_SPACE_LEFT : ST_FILLED,
                 c, p_fill, p_ext, 8'h00, 1'b0);
      end
    end
  endfunction

  // offers one item from a falling edge and returns at the falling edge after its transfer
  task automatic send_item(input op_t op, input logic [CHUNK_W-1:0] chunk, input logic fin,
                           input logic typed, input packer_result_t want);
    int gap;
    gap = pick_gap(snd_quiet);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.operation   <= op;
    in_chan.chunk_len   <= chunk;
    in_chan.final_block <= fin;
    do @(posedge clk); while (!in_chan.ready);
    predict_packing(op, chunk, fin);
    // hand-written expectation takes the place of the predicted one
    if (typed) begin
      void'(packer_results_due.pop_back());
      packer_results_due.push_back(want);
    end
    @(negedge clk);
  endtask

  // length register is only written with the block quiet
  task automatic write_block_len(input logic [LEN_W-1:0] len);
    in_chan.valid <= 1'b0;
    while (packer_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    p_blen = len;
  endtask

  // mostly well-formed block filling driven by the predicted fill, some noise
  task automatic random_item();
    int dlen;
    int space;
    int k;
    op_t op;
    logic [CHUNK_W-1:0] chunk;
    logic fin;
    dlen  = (int'(p_blen) > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : int'(p_blen);
    space = (p_fill < dlen) ? dlen - p_fill : 0;
    fin   = ($urandom_range(4) == 0);
    op    = OP_APPEND;
    k     = $urandom_range(99);
    if (k < 8) begin
      op    = op_t'($urandom_range(1));
      chunk = CHUNK_W'($urandom_range(2047));
    end else if (space == 0 || (p_li_cnt > 0 && k < 22)) begin
      // block done or cut short: read it out
      op    = OP_READOUT;
      chunk = CHUNK_W'($urandom_range(2047));
    end else begin
      k = $urandom_range(99);
      if (k < 30)      chunk = CHUNK_W'($urandom_range(3));
      else if (k < 55) chunk = CHUNK_W'($urandom_range(space));
      else if (k < 65) chunk = CHUNK_W'(space);
      else if (k < 72) chunk = CHUNK_W'(space - 1);
      else if (k < 87) chunk = CHUNK_W'(space + $urandom_range(1, 40));
      else             chunk = CHUNK_W'($urandom_range(2047));
    end
    send_item(op, chunk, fin, 1'b0, '0);
  endtask

  // result side: random ready gaps plus one long hold-off while the sender keeps going
  initial begin : result_sink
    int gap;
    logic hold_pending;
    hold_pending   = 1'b1;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_pending && results_seen >= HOLD_AFTER) begin
        hold_pending = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = pick_gap(rcv_quiet);
        if (gap > 0) begin
          out_chan.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // compare every result transfer against the oldest expectation
  always @(posedge clk) begin
    packer_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (packer_results_due.size() == 0) begin
        report_mismatch("result with nothing due, status", int'(out_chan.status), -1);
      end else begin
        want = packer_results_due.pop_front();
        if (out_chan.status !== want.status)
          report_mismatch("status", int'(out_chan.status), int'(want.status));
        if (out_chan.taken_count !== want.taken)
          report_mismatch("taken_count", int'(out_chan.taken_count), int'(want.taken));
        if (out_chan.fill_offset !== want.fill)
          report_mismatch("fill_offset", int'(out_chan.fill_offset), int'(want.fill));
        if (out_chan.ext_present !== want.ext)
          report_mismatch("ext_present", int'(out_chan.ext_present), int'(want.ext));
        if (out_chan.li_octet !== want.li)
          report_mismatch("li_octet", int'(out_chan.li_octet), int'(want.li));
        if (out_chan.last_octet !== want.last)
          report_mismatch("last_octet", int'(out_chan.last_octet), int'(want.last));
      end
    end
  end

  initial begin : stimulus
    int i;
    int ph;
    stim_row_t row;
    packer_result_t want;
    logic [LEN_W-1:0] len_plan [RAND_PHASES];

    // everything known from time zero, reset asserted at the start
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.operation   = OP_APPEND;
    in_chan.chunk_len   = '0;
    in_chan.final_block = 1'b0;
    p_blen              = CFG_RESET;
    p_fill              = 0;
    p_li_cnt            = 0;
    p_ext               = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (i = 0; i < N_DIR; i++) begin
      row = dir_rows[i];
      want.status = row.st;
      want.taken  = row.taken;
      want.fill   = row.fill;
      want.ext    = row.ext;
      want.li     = 8'h00;
      want.last   = 1'b0;
      case (row.kind)
        ROW_SET_LEN: write_block_len(row.chunk[LEN_W-1:0]);
        ROW_READOUT: send_item(OP_READOUT, row.chunk, row.fin, 1'b0, want);
        default:     send_item(OP_APPEND, row.chunk, row.fin, row.typed, want);
      endcase
    end

    // fill the LI store with zero-length chunks, one more than it holds, then a
    // full-length readout; the long hold-off on the result side lands in here
    write_block_len(7'd64);
    for (i = 0; i < BURST_LIS; i++)
      send_item(OP_APPEND, '0, 1'b0, 1'b0, '0);
    send_item(OP_READOUT, '0, 1'b0, 1'b0, '0);

    // random phases over several block lengths, extremes included
    len_plan[0] = 7'd37;
    len_plan[1] = 7'd1;
    len_plan[2] = 7'd2;
    len_plan[3] = 7'd64;
    len_plan[4] = CFG_RESET;
    len_plan[5] = LEN_W'($urandom_range(3, 63));
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      write_block_len(len_plan[ph]);
      for (i = 0; i < RAND_ITEMS; i++)
        random_item();
    end

    // drain, then a quiet tail to catch stray results
    in_chan.valid <= 1'b0;
    while (packer_results_due.size() != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);
    if (err_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rlcsp_pkg.sv
rtl/rlcsp_if.sv
rtl/rlcsp_ctrl.sv
rtl/rlcsp_dpath.sv
rtl/rlc_block_segment_packer.sv
rtl/rlcsp_chk.sv
tb/sv/rlc_block_segment_packer_tb.sv
